// ----- design/ipe_pkg.sv -----
package ipe_pkg;

    localparam int unsigned PART_W  = 6;
    localparam int unsigned TDATA_W = 8;

    typedef struct packed {
        logic in_ready;
        logic load_restart;
        logic set_finished;
        logic scan_init;
        logic scan_step;
        logic scan_lower;
        logic fill_copy;
        logic fill_end;
        logic emit;
        logic exh_load;
    } t_cmd;

    typedef struct packed {
        logic in_restart;
        logic in_total_zero;
        logic finished;
        logic rd_one;
        logic rd_zero;
        logic k_zero;
        logic rem_gt;
        logic fill_ovf;
        logic out_free;
        logic emit_done;
    } t_status;

endpackage

// ----- design/ipe_ctrl.sv -----
module ipe_ctrl
    import ipe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_SCAN_RD  = 6'b000010,
        S_SCAN_CHK = 6'b000100,
        S_FILL     = 6'b001000,
        S_EMIT     = 6'b010000,
        S_EXH      = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (s_axis_tvalid) begin
                    if (i_status.in_restart) begin
                        if (i_status.in_total_zero) begin
                            o_cmd.set_finished = 1'b1;
                            n_state = S_EXH;
                        end else begin
                            o_cmd.load_restart = 1'b1;
                            n_state = S_EMIT;
                        end
                    end else if (i_status.finished) begin
                        n_state = S_EXH;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_status.rd_one) begin
                    if (i_status.k_zero) begin
                        o_cmd.set_finished = 1'b1;
                        n_state = S_EXH;
                    end else begin
                        o_cmd.scan_step = 1'b1;
                    end
                end else if (i_status.rd_zero) begin
                    o_cmd.set_finished = 1'b1;
                    n_state = S_EXH;
                end else begin
                    o_cmd.scan_lower = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_status.fill_ovf) begin
                    o_cmd.set_finished = 1'b1;
                    n_state = S_EXH;
                end else if (i_status.rem_gt) begin
                    o_cmd.fill_copy = 1'b1;
                end else begin
                    o_cmd.fill_end = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_done) begin
                    n_state = S_IDLE;
                end
            end
            S_EXH: begin
                if (i_status.out_free) begin
                    o_cmd.exh_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = o_cmd.in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/ipe_dp.sv -----
module ipe_dp
    import ipe_pkg::*;
#(
    parameter int unsigned MAX_TOTAL = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [5:0] total
    input  logic               s_axis_tuser,   // [0] restart
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [5:0] part_value
    output logic               m_axis_tlast,   // [0] last_part
    output logic               m_axis_tuser    // [0] exhausted
);

    localparam int unsigned IDX_W = $clog2(MAX_TOTAL);
    localparam int unsigned VAL_W = $clog2(MAX_TOTAL + 1);

    logic [PART_W-1:0] r_parts [MAX_TOTAL];
    logic [PART_W-1:0] r_rdata;

    logic [IDX_W-1:0]  r_k,   n_k;
    logic [IDX_W-1:0]  r_top, n_top;
    logic [IDX_W-1:0]  r_i,   n_i;
    logic [VAL_W-1:0]  r_rem, n_rem;
    logic [VAL_W-1:0]  r_cur, n_cur;
    logic              r_fin, n_fin;
    logic              r_pend;

    logic              r_out_valid, n_out_valid;
    logic [PART_W-1:0] r_out_part,  n_out_part;
    logic              r_out_last,  n_out_last;
    logic              r_out_exh,   n_out_exh;

    logic [PART_W-1:0] w_total;
    logic [PART_W-1:0] w_total_sat;
    logic [IDX_W:0]    w_kp1;
    logic              w_out_free;
    logic              w_emit_load;
    logic [IDX_W-1:0]  w_rd_addr;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    logic [PART_W-1:0] w_wdata;

    assign w_total     = s_axis_tdata[PART_W-1:0];
    assign w_total_sat = (int'(w_total) > MAX_TOTAL) ? PART_W'(MAX_TOTAL) : w_total;
    assign w_kp1       = {1'b0, r_k} + (IDX_W + 1)'(1);
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_emit_load = i_cmd.emit && r_pend && w_out_free;

    always_comb begin
        if (i_cmd.emit) begin
            w_rd_addr = w_emit_load ? r_i + IDX_W'(1) : r_i;
        end else if (i_cmd.scan_step) begin
            w_rd_addr = r_k - IDX_W'(1);
        end else begin
            w_rd_addr = r_k;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = PART_W'(r_cur);
        if (i_cmd.load_restart) begin
            w_we    = 1'b1;
            w_waddr = '0;
            w_wdata = w_total_sat;
        end else if (i_cmd.scan_lower) begin
            w_we    = 1'b1;
            w_waddr = r_k;
            w_wdata = r_rdata - PART_W'(1);
        end else if (i_cmd.fill_copy) begin
            w_we    = 1'b1;
            w_waddr = w_kp1[IDX_W-1:0];
            w_wdata = PART_W'(r_cur);
        end else if (i_cmd.fill_end) begin
            w_we    = 1'b1;
            w_waddr = w_kp1[IDX_W-1:0];
            w_wdata = PART_W'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_parts[w_waddr] <= w_wdata;
        end
        r_rdata <= r_parts[w_rd_addr];
    end

    always_comb begin
        n_k   = r_k;
        n_top = r_top;
        n_i   = r_i;
        n_rem = r_rem;
        n_cur = r_cur;
        n_fin = r_fin;
        if (i_cmd.load_restart) begin
            n_top = '0;
            n_fin = 1'b0;
            n_i   = '0;
        end
        if (i_cmd.set_finished) begin
            n_fin = 1'b1;
        end
        if (i_cmd.scan_init) begin
            n_k   = r_top;
            n_rem = '0;
        end
        if (i_cmd.scan_step) begin
            n_k   = r_k - IDX_W'(1);
            n_rem = r_rem + VAL_W'(1);
        end
        if (i_cmd.scan_lower) begin
            n_cur = VAL_W'(r_rdata - PART_W'(1));
            n_rem = r_rem + VAL_W'(1);
        end
        if (i_cmd.fill_copy) begin
            n_rem = r_rem - r_cur;
            n_k   = w_kp1[IDX_W-1:0];
        end
        if (i_cmd.fill_end) begin
            n_top = w_kp1[IDX_W-1:0];
            n_i   = '0;
        end
        if (w_emit_load) begin
            n_i = r_i + IDX_W'(1);
        end
    end

    always_comb begin
        n_out_part  = r_out_part;
        n_out_last  = r_out_last;
        n_out_exh   = r_out_exh;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (w_emit_load) begin
            n_out_valid = 1'b1;
            n_out_part  = r_rdata;
            n_out_last  = (r_i == r_top);
            n_out_exh   = 1'b0;
        end else if (i_cmd.exh_load) begin
            n_out_valid = 1'b1;
            n_out_part  = '0;
            n_out_last  = 1'b1;
            n_out_exh   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_fin       <= 1'b1;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_fin       <= n_fin;
            r_pend      <= i_cmd.emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_i        <= n_i;
        r_rem      <= n_rem;
        r_cur      <= n_cur;
        r_out_part <= n_out_part;
        r_out_last <= n_out_last;
        r_out_exh  <= n_out_exh;
    end

    assign o_status.in_restart    = s_axis_tuser;
    assign o_status.in_total_zero = (w_total == '0);
    assign o_status.finished      = r_fin;
    assign o_status.rd_one        = (r_rdata == PART_W'(1));
    assign o_status.rd_zero       = (r_rdata == '0);
    assign o_status.k_zero        = (r_k == '0);
    assign o_status.rem_gt        = (r_rem > r_cur);
    assign o_status.fill_ovf      = (w_kp1 >= (IDX_W + 1)'(MAX_TOTAL));
    assign o_status.out_free      = w_out_free;
    assign o_status.emit_done     = w_emit_load && (r_i == r_top);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(TDATA_W - PART_W){1'b0}}, r_out_part};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_exh;

endmodule

// ----- design/integer_partition_enumerator.sv -----
// A restart beat emits its total as the first part; an advance beat first scans
// the trailing ones and fills copies before its first part.
// A new beat is taken only after all parts of the last one, or its exhausted
// beat, have been loaded into the output register.
// Reset: synchronous active low; clears to no active enumeration, output empty.
module integer_partition_enumerator
    import ipe_pkg::*;
#(
    parameter int unsigned MAX_TOTAL = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [5:0] total
    input  logic               s_axis_tuser,   // [0] restart
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [5:0] part_value
    output logic               m_axis_tlast,   // [0] last_part
    output logic               m_axis_tuser    // [0] exhausted
);

    t_cmd    w_cmd;
    t_status w_status;

    ipe_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    ipe_dp #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

`ifndef SYNTH
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken again before the item finished");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_restart, w_cmd.scan_lower, w_cmd.fill_copy, w_cmd.fill_end}))
        else $error("more than one memory write in a cycle");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit || w_cmd.exh_load) |-> !s_axis_tready)
        else $error("input ready while results are pending");

    a_exh_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exh_load |-> w_status.out_free)
        else $error("exhausted beat loaded over a held result");
`endif

endmodule

// ----- dv/integer_partition_enumerator_test.sv -----
`timescale 1ns / 1ps

module integer_partition_enumerator_test;
    import ipe_pkg::*;

    localparam int MAX_TOTAL   = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 4000;
    localparam int BEAT_TARGET = 190;
    localparam int CALM_TAIL   = 160;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata  = '0;   // [5:0] total
    logic               s_axis_tuser  = 1'b0; // [0] restart
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;         // [5:0] part_value
    logic               m_axis_tlast;         // [0] last_part
    logic               m_axis_tuser;         // [0] exhausted

    typedef struct packed {
        logic [PART_W-1:0] value;
        logic              last;
        logic              exhausted;
    } t_part_beat;

    class partition_tracker;
        int         held [MAX_TOTAL];
        int         top;
        bit         finished;
        t_part_beat pending_parts [$];
        int         errors;

        function new();
            foreach (held[i]) held[i] = 0;
            top      = 0;
            finished = 1'b1;
            errors   = 0;
        endfunction

        task report(string what);
            errors++;
            $display("%0t: mismatch, %s", $time, what);
        endtask

        function int pending();
            return pending_parts.size();
        endfunction

        function void push_exhausted();
            t_part_beat b;
            b.value     = '0;
            b.last      = 1'b1;
            b.exhausted = 1'b1;
            pending_parts = {pending_parts, b};
        endfunction

        function void push_partition();
            t_part_beat b;
            for (int i = 0; i <= top; i++) begin
                b.value     = PART_W'(held[i]);
                b.last      = (i == top);
                b.exhausted = 1'b0;
                pending_parts = {pending_parts, b};
            end
        endfunction

        function void note_request(logic restart, logic [PART_W-1:0] total);
            int k;
            int rem;
            bit ok;
            if (restart) begin
                if (total == 0) begin
                    finished = 1'b1;
                    push_exhausted();
                end else begin
                    held[0]  = (int'(total) > MAX_TOTAL) ? MAX_TOTAL : int'(total);
                    top      = 0;
                    finished = 1'b0;
                    push_partition();
                end
            end else if (finished || top >= MAX_TOTAL) begin
                push_exhausted();
            end else begin
                k   = top;
                rem = 0;
                ok  = 1'b1;
                // strip trailing ones into the remainder
                while (ok && held[k] == 1) begin
                    rem++;
                    if (k == 0) ok = 1'b0;
                    else k--;
                end
                if (ok && held[k] == 0) ok = 1'b0;
                if (ok) begin
                    held[k]--;
                    rem++;
                    while (ok && rem > held[k]) begin
                        if (k + 1 >= MAX_TOTAL) begin
                            ok = 1'b0;
                        end else begin
                            held[k + 1] = held[k];
                            rem -= held[k];
                            k++;
                        end
                    end
                    if (ok && k + 1 >= MAX_TOTAL) ok = 1'b0;
                    if (ok) begin
                        held[k + 1] = rem;
                        top         = k + 1;
                    end
                end
                if (ok) begin
                    push_partition();
                end else begin
                    finished = 1'b1;
                    push_exhausted();
                end
            end
        endfunction

        task check_part(logic [PART_W-1:0] value, logic last, logic exhausted);
            t_part_beat want;
            if (pending_parts.size() == 0) begin
                report($sformatf("unexpected beat, part_value %0d last %0b exhausted %0b",
                                 value, last, exhausted));
            end else begin
                want = pending_parts.pop_front();
                if (value !== want.value)
                    report($sformatf("part_value %0d, expected %0d", value, want.value));
                if (last !== want.last)
                    report($sformatf("last_part %0b, expected %0b", last, want.last));
                if (exhausted !== want.exhausted)
                    report($sformatf("exhausted %0b, expected %0b", exhausted, want.exhausted));
            end
        endtask
    endclass

    partition_tracker tracker;
    bit               idling     = 1'b0;
    bit               hold_off   = 1'b0;
    int               beats_sent = 0;

    integer_partition_enumerator #(
        .MAX_TOTAL(MAX_TOTAL)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_beat(input logic restart, input logic [PART_W-1:0] total);
        if (idling && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(TDATA_W - PART_W){1'b0}}, total};
        s_axis_tuser  <= restart;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_request(restart, total);
        beats_sent++;
    endtask

    task automatic run_enumeration(input int total, input int advances);
        send_beat(1'b1, PART_W'(total));
        repeat (advances) send_beat(1'b0, PART_W'($urandom_range(0, 63)));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    initial begin : receiver
        while (!i_rst_n) @(posedge i_clk);
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_part(m_axis_tdata[PART_W-1:0], m_axis_tlast, m_axis_tuser);
            if (hold_off) begin
                hold_off = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL integer_partition_enumerator");
        $finish;
    end

    initial begin : stimulus
        int pick;
        int total;
        tracker = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idling = 1'b1;

        // advance with nothing active, then restart with zero
        send_beat(1'b0, 6'd0);
        send_beat(1'b0, 6'd63);
        send_beat(1'b1, 6'd0);
        send_beat(1'b0, 6'd5);
        // single one, then past the all-ones partition
        send_beat(1'b1, 6'd1);
        send_beat(1'b0, 6'd0);
        // saturated and full-scale totals
        run_enumeration(63, 2);
        run_enumeration(32, 1);
        send_beat(1'b1, 6'd33);
        // full walk of five and two, running off the end
        run_enumeration(5, 8);
        run_enumeration(2, 2);

        // hold the output while input keeps coming
        hold_off = 1'b1;
        run_enumeration(8, 25);
        wait_drained();

        while (beats_sent < BEAT_TARGET) begin
            idling = (beats_sent < CALM_TAIL);
            pick   = $urandom_range(0, 9);
            if (pick < 2) begin
                send_beat(1'($urandom_range(0, 1)), PART_W'($urandom_range(0, 63)));
            end else begin
                if (pick < 7)      total = $urandom_range(1, 9);
                else if (pick < 9) total = $urandom_range(10, 14);
                else               total = $urandom_range(15, 63);
                run_enumeration(total, $urandom_range(0, 32));
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS integer_partition_enumerator");
        else
            $display("FAIL integer_partition_enumerator");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ipe_pkg.sv
design/ipe_ctrl.sv
design/ipe_dp.sv
design/integer_partition_enumerator.sv
dv/integer_partition_enumerator_test.sv
